>>> sv/int64_to_decimal_ascii_core_defines.svh
// Assertion macros used by the checker file.
`ifndef INT64_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`define INT64_TO_DECIMAL_ASCII_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define I64DA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("i64da check failed");

// Next-cycle implication, disabled while reset is asserted.
`define I64DA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("i64da check failed");

// Implication that is also checked during reset.
`define I64DA_ASSERT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("i64da check failed");

`endif

>>> sv/i64da_pkg.sv
`timescale 1ns / 1ps

package i64da_pkg;

    localparam int VALUE_W = 64;
    localparam int DIGITS  = 20;
    localparam int BCD_W   = DIGITS * 4;
    localparam int LEN_W   = 5;
    localparam int CHAR_W  = 8;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

    localparam logic [7:0] BUF_BYTES_RESET = 8'd64;

    // One classified value: sign and magnitude
    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } t_job;

    // One result word
    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
        logic [LEN_W-1:0]  length;
        logic              no_room;
    } t_result;

endpackage

>>> sv/int64_to_decimal_ascii_core.sv
`timescale 1ns / 1ps
// Path: a value passes the job queue, the load, 64 shift-add steps and the length scan before
// its first character reaches the result queue; one character per cycle follows while that queue is not full.
// The one-bit-per-cycle binary to decimal converter finishes each value, a text of 1..20 characters
// or a lone word when it does not fit, before it takes the next value.
// Reset: synchronous, active low; empties both queues, idles the converter, buffer size 64.

module int64_to_decimal_ascii_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [i64da_pkg::VALUE_W-1:0] i_value,
    input  logic                          push,
    output logic                          full,
    output logic [i64da_pkg::CHAR_W-1:0]  o_character,
    output logic                          o_last,
    output logic [i64da_pkg::LEN_W-1:0]   o_length,
    output logic                          o_no_room,
    output logic                          empty,
    input  logic                          pop,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [7:0]                    i_cfg_data
);
    import i64da_pkg::*;

    logic [7:0] r_buffer_bytes;
    t_job       w_job;
    logic       w_job_valid;
    logic       w_job_ready;
    t_result    w_res;
    logic       w_res_valid;
    logic       w_res_full;
    t_result    w_out;

    // Buffer size register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_bytes <= BUF_BYTES_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_buffer_bytes <= i_cfg_data;
        end
    end

    i64da_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value),
        .i_push      (push),
        .o_full      (full),
        .o_job       (w_job),
        .o_job_valid (w_job_valid),
        .i_job_ready (w_job_ready)
    );

    i64da_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (w_job),
        .i_job_valid    (w_job_valid),
        .o_job_ready    (w_job_ready),
        .i_buffer_bytes (r_buffer_bytes),
        .o_res          (w_res),
        .o_res_valid    (w_res_valid),
        .i_res_full     (w_res_full)
    );

    i64da_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .o_empty (empty),
        .o_data  (w_out),
        .i_pop   (pop)
    );

    assign o_character = w_out.character;
    assign o_last      = w_out.last;
    assign o_length    = w_out.length;
    assign o_no_room   = w_out.no_room;

endmodule

>>> sv/i64da_front.sv
`timescale 1ns / 1ps

module i64da_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [i64da_pkg::VALUE_W-1:0]   i_value,
    input  logic                            i_push,
    output logic                            o_full,
    output i64da_pkg::t_job                 o_job,
    output logic                            o_job_valid,
    input  logic                            i_job_ready
);
    import i64da_pkg::*;

    t_job       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    t_job       w_job_in;
    logic       w_wr;
    logic       w_rd;

    // Classify: sign bit and two's complement magnitude (exact for the most negative value)
    always_comb begin
        w_job_in.neg = i_value[VALUE_W-1];
        w_job_in.mag = i_value[VALUE_W-1] ? (~i_value + 64'd1) : i_value;
    end

    assign o_full      = (r_count == 2'd2);
    assign o_job_valid = (r_count != 2'd0);
    assign o_job       = r_q[r_rd_ptr];
    assign w_wr        = i_push & ~o_full;
    assign w_rd        = o_job_valid & i_job_ready;

    // Two-entry job queue toward the converter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_wr) r_wr_ptr <= ~r_wr_ptr;
            if (w_rd) r_rd_ptr <= ~r_rd_ptr;
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_q[r_wr_ptr] <= w_job_in;
    end

endmodule

>>> sv/i64da_back.sv
`timescale 1ns / 1ps

module i64da_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  i64da_pkg::t_job   i_job,
    input  logic              i_job_valid,
    output logic              o_job_ready,
    input  logic [7:0]        i_buffer_bytes,
    output i64da_pkg::t_result o_res,
    output logic              o_res_valid,
    input  logic              i_res_full
);
    import i64da_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    localparam logic [5:0] STEP_LAST = 6'(VALUE_W - 1);

    logic [1:0]         r_state;
    logic               r_neg;
    logic [VALUE_W-1:0] r_bin;
    logic [BCD_W-1:0]   r_bcd;
    logic [5:0]         r_cnt;
    logic [LEN_W-1:0]   r_len;
    logic [LEN_W-1:0]   r_pos;

    logic [BCD_W-1:0]   w_bcd_adj;
    logic [LEN_W-1:0]   w_digits;
    logic [LEN_W-1:0]   w_digit_idx;
    logic [3:0]         w_nib;
    logic               w_no_room;
    logic               w_last;

    // Double dabble: add 3 to every digit at 5 or above before the shift
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            w_bcd_adj[i*4 +: 4] = (r_bcd[i*4 +: 4] >= 4'd5) ? (r_bcd[i*4 +: 4] + 4'd3)
                                                             : r_bcd[i*4 +: 4];
        end
    end

    // Digit count: highest nonzero digit, at least one
    always_comb begin
        w_digits = 5'd1;
        for (int i = 0; i < DIGITS; i++) begin
            if (r_bcd[i*4 +: 4] != 4'd0) w_digits = 5'(i + 1);
        end
    end

    // Digit for the current text position, counted from the least significant end
    assign w_digit_idx = r_len - 5'd1 - r_pos;
    always_comb begin
        w_nib = 4'd0;
        for (int i = 0; i < DIGITS; i++) begin
            if (w_digit_idx == 5'(i)) w_nib = r_bcd[i*4 +: 4];
        end
    end

    assign w_no_room = ({3'b000, r_len} >= i_buffer_bytes);
    assign w_last    = w_no_room | (r_pos == (r_len - 5'd1));

    // Result word
    always_comb begin
        o_res.last    = w_last;
        o_res.no_room = w_no_room;
        o_res.length  = w_no_room ? 5'd0 : r_len;
        if (w_no_room)
            o_res.character = CHAR_NUL;
        else if (r_neg && (r_pos == 5'd0))
            o_res.character = CHAR_MINUS;
        else
            o_res.character = CHAR_ZERO | {4'b0000, w_nib};
    end

    assign o_res_valid = (r_state == S_EMIT);
    assign o_job_ready = (r_state == S_IDLE);

    // Sequencer: load, 64 shift steps, length scan, emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_job_valid) r_state <= S_CONV;
                S_CONV: if (r_cnt == STEP_LAST) r_state <= S_SCAN;
                S_SCAN: r_state <= S_EMIT;
                S_EMIT: if (!i_res_full && w_last) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_neg <= i_job.neg;
                r_bin <= i_job.mag;
                r_bcd <= '0;
                r_cnt <= 6'd0;
            end
            S_CONV: begin
                r_bcd <= {w_bcd_adj[BCD_W-2:0], r_bin[VALUE_W-1]};
                r_bin <= {r_bin[VALUE_W-2:0], 1'b0};
                r_cnt <= r_cnt + 6'd1;
            end
            S_SCAN: begin
                r_len <= w_digits + {4'b0000, r_neg};
                r_pos <= 5'd0;
            end
            S_EMIT: begin
                if (!i_res_full) r_pos <= r_pos + 5'd1;
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

endmodule

>>> sv/i64da_outq.sv
`timescale 1ns / 1ps

module i64da_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  i64da_pkg::t_result  i_data,
    output logic                o_full,
    output logic                o_empty,
    output i64da_pkg::t_result  o_data,
    input  logic                i_pop
);
    import i64da_pkg::*;

    t_result    r_q [4];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;
    logic       w_wr;
    logic       w_rd;

    assign o_full  = (r_count == 3'd4);
    assign o_empty = (r_count == 3'd0);
    assign o_data  = r_q[r_rd_ptr];
    assign w_wr    = i_push & ~o_full;
    assign w_rd    = i_pop & ~o_empty;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            if (w_wr) r_wr_ptr <= r_wr_ptr + 2'd1;
            if (w_rd) r_rd_ptr <= r_rd_ptr + 2'd1;
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 3'd1;
                2'b01:   r_count <= r_count - 3'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_q[r_wr_ptr] <= i_data;
    end

endmodule

>>> sv/i64da_checker.sv
`timescale 1ns / 1ps
`include "int64_to_decimal_ascii_core_defines.svh"

module i64da_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic [7:0] o_character,
    input logic       o_last,
    input logic [4:0] o_length,
    input logic       o_no_room,
    input logic       empty,
    input logic       pop
);

    // Nothing waits on the result side right after reset
    `I64DA_ASSERT_RST(a_empty_after_reset, i_clk, !i_rst_n, empty)

    // A no-room word is a final word with zero length and a NUL character
    `I64DA_ASSERT_NOW(a_no_room_shape, i_clk, i_rst_n, !empty && o_no_room, o_last && (o_length == 5'd0) && (o_character == 8'h00))

    // A text word carries a length of 1..20
    `I64DA_ASSERT_NOW(a_length_range, i_clk, i_rst_n, !empty && !o_no_room, (o_length != 5'd0) && (o_length <= 5'd20))

    // A waiting word holds until taken
    `I64DA_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_character) && $stable(o_last))

endmodule

bind int64_to_decimal_ascii_core i64da_checker u_i64da_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_character (o_character),
    .o_last      (o_last),
    .o_length    (o_length),
    .o_no_room   (o_no_room),
    .empty       (empty),
    .pop         (pop)
);
